// File: sv/rotated_sorted_array_search_assert.svh
// Assertion macros shared by the rotated sorted array search RTL.
`ifndef ROTATED_SORTED_ARRAY_SEARCH_ASSERT_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define RSAS_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rsas: invariant violated");
`define RSAS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsas: implication violated");
`define RSAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsas: next-cycle check violated");
`else
`define RSAS_ASSERT_ALWAYS(label, cond)
`define RSAS_ASSERT_IMPL(label, ante, cons)
`define RSAS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: sv/rsas_pkg.sv
// Package with types and constants of the rotated sorted array search block.
package rsas_pkg;

  localparam int VALUE_W     = 32;
  localparam int OUT_W       = 11;
  localparam int OUT_TDATA_W = 16;
  localparam int DEPTH_DEF   = 1024;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST,
    S_LAST_CHK,
    S_PV_CALC,
    S_PV_RM,
    S_PV_RP,
    S_PV_RH,
    S_PV_DEC,
    S_L_INIT,
    S_R_INIT,
    S_BS_CALC,
    S_BS_RD,
    S_BS_CMP,
    S_BS_END,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    ADDR_WR,
    ADDR_LAST,
    ADDR_MID,
    ADDR_PREV,
    ADDR_HI
  } addr_sel_t;

  typedef struct packed {
    logic      store;
    logic      ld_key;
    addr_sel_t addr_sel;
    logic      cap_a;
    logic      pv_init;
    logic      calc_mid;
    logic      lo_inc;
    logic      hi_set_mid;
    logic      hi_dec;
    logic      pivot_mid;
    logic      pivot_zero;
    logic      bs_left;
    logic      bs_right;
    logic      bs_found;
    logic      save_left;
    logic      res_none;
    logic      res_last;
    logic      res_final;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic lo_le_hi;
    logic mid_zero;
    logic rd_eq;
    logic rd_gt_key;
    logic va_lt_rd;
    logic va_gt_rd;
    logic hi_eq_mid;
    logic pivot_is_zero;
  } sts_t;

  // Masks a sign-extended index down to the result width.
  function automatic logic [OUT_W-1:0] idx_to_out(logic signed [31:0] v);
    return v[OUT_W-1:0];
  endfunction

endpackage

// File: sv/rotated_sorted_array_search.sv
// Top level of the rotated sorted array search block.
//
//   channel | direction | payload
//   in_     | slave     | tdata[31:0] value; tuser[0] operation, tuser[1] restart
//   out_    | master    | tdata[10:0] found_index, upper bits zero
//
// A store request gives no result. A search request first checks the last element
// and reports its index on a hit; otherwise it probes for the pivot and then runs a
// binary search on the part before and the part after it, each with about log2 of
// the element count in probes. All memory reads share the single RAM port.
// Reset clears the element count and the controller; the memory is not cleared.
// Only one request is in work at a time; a result holds until out_tready is high.
module rotated_sorted_array_search #(
  parameter int DEPTH = rsas_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rsas_pkg::VALUE_W-1:0]        in_tdata,   // [31:0] value
  input  logic [1:0]                          in_tuser,   // [0] operation, [1] restart
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rsas_pkg::OUT_TDATA_W-1:0]    out_tdata   // [10:0] found_index
);
  import rsas_pkg::*;

  `include "rotated_sorted_array_search_assert.svh"

  cmd_t             cmd;
  sts_t             sts;
  logic [OUT_W-1:0] found_index;

  rsas_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_operation(in_tuser[0]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .sts         (sts),
    .cmd         (cmd)
  );

  rsas_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   ($signed(in_tdata)),
    .in_restart (in_tuser[1]),
    .found_index(found_index)
  );

  assign out_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, found_index};

  // The block never takes a request while a result is pending.
  `RSAS_ASSERT_ALWAYS(a_no_accept_while_out, !(in_tready && out_tvalid))
  // A search on an empty store reports not found.
  `RSAS_ASSERT_IMPL(a_empty_not_found, out_tvalid && sts.n_zero, out_tdata[10:0] == 11'h7FF)
  // An accepted search request occupies the block in the following cycle.
  `RSAS_ASSERT_NEXT(a_search_busy, in_tvalid && in_tready && in_tuser[0], !in_tready)

endmodule

// File: sv/rsas_ram.sv
// Generic single-port RAM with registered read data.
module rsas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/rsas_dp.sv
// Datapath: element memory, element count, search bounds and result register.
module rsas_dp #(
  parameter int DEPTH = rsas_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rsas_pkg::cmd_t                     cmd,
  output rsas_pkg::sts_t                     sts,
  input  logic signed [rsas_pkg::VALUE_W-1:0] in_value,
  input  logic                               in_restart,
  output logic [rsas_pkg::OUT_W-1:0]         found_index
);
  import rsas_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = CW + 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CW-1:0]             count_r, count_nxt;
  logic signed [VALUE_W-1:0] key_r, va_r;
  logic signed [IW-1:0]      lo_r, hi_r, mid_r, pivot_r, bs_res_r, left_r;
  logic [OUT_W-1:0]          res_r;

  logic signed [IW-1:0]      n_minus1, mid_calc, addr_idx, best;
  logic [VALUE_W-1:0]        ram_q;
  logic signed [VALUE_W-1:0] rdata;
  logic                      we;

  assign n_minus1 = $signed({1'b0, count_r}) - IW'(1);
  assign mid_calc = lo_r + ((hi_r - lo_r) >>> 1);
  assign rdata    = $signed(ram_q);
  assign best     = (left_r > bs_res_r) ? left_r : bs_res_r;

  // A store with restart always lands at index zero; otherwise a full store drops it.
  assign we = cmd.store && (in_restart || (count_r < CW'(DEPTH)));

  always_comb begin
    count_nxt = count_r;
    if (we) begin
      count_nxt = in_restart ? CW'(1) : count_r + CW'(1);
    end
  end

  always_comb begin
    case (cmd.addr_sel)
      ADDR_WR:   addr_idx = in_restart ? '0 : $signed({1'b0, count_r});
      ADDR_LAST: addr_idx = n_minus1;
      ADDR_MID:  addr_idx = mid_r;
      ADDR_PREV: addr_idx = mid_r - IW'(1);
      ADDR_HI:   addr_idx = hi_r;
      default:   addr_idx = mid_r;
    endcase
  end

  rsas_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .addr (addr_idx[AW-1:0]),
    .wdata(in_value),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_key) begin
      key_r  <= in_value;
      left_r <= '1;
    end else if (cmd.save_left) begin
      left_r <= bs_res_r;
    end

    if (cmd.cap_a) begin
      va_r <= rdata;
    end

    if (cmd.calc_mid) begin
      mid_r <= mid_calc;
    end

    if (cmd.pv_init) begin
      lo_r <= '0;
      hi_r <= n_minus1;
    end else if (cmd.bs_left) begin
      lo_r <= '0;
      hi_r <= pivot_r - IW'(1);
    end else if (cmd.bs_right) begin
      lo_r <= pivot_r;
      hi_r <= n_minus1;
    end else if (cmd.lo_inc) begin
      lo_r <= mid_r + IW'(1);
    end else if (cmd.hi_set_mid) begin
      hi_r <= mid_r;
    end else if (cmd.hi_dec) begin
      hi_r <= mid_r - IW'(1);
    end

    if (cmd.pivot_mid) begin
      pivot_r <= mid_r;
    end else if (cmd.pivot_zero) begin
      pivot_r <= '0;
    end

    if (cmd.bs_left || cmd.bs_right) begin
      bs_res_r <= '1;
    end else if (cmd.bs_found) begin
      bs_res_r <= mid_r;
    end

    if (cmd.res_none) begin
      res_r <= '1;
    end else if (cmd.res_last) begin
      res_r <= idx_to_out(32'(n_minus1));
    end else if (cmd.res_final) begin
      res_r <= idx_to_out(32'(best));
    end
  end

  assign found_index = res_r;

  always_comb begin
    sts.n_zero        = (count_r == '0);
    sts.lo_le_hi      = (lo_r <= hi_r);
    sts.mid_zero      = (mid_r == '0);
    sts.rd_eq         = (rdata == key_r);
    sts.rd_gt_key     = (rdata > key_r);
    sts.va_lt_rd      = (va_r < rdata);
    sts.va_gt_rd      = (va_r > rdata);
    sts.hi_eq_mid     = (hi_r == mid_r);
    sts.pivot_is_zero = (pivot_r == '0);
  end

endmodule

// File: sv/rsas_ctrl.sv
// Controller: state machine sequencing the last-element check, pivot and binary searches.
module rsas_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           in_operation,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  rsas_pkg::sts_t sts,
  output rsas_pkg::cmd_t cmd
);
  import rsas_pkg::*;

  state_t state_r, state_nxt;
  // Low while searching the part before the pivot, high for the part after it.
  logic   side_r, side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_operation) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST:     state_nxt = sts.n_zero ? S_OUT : S_LAST_CHK;
      S_LAST_CHK: state_nxt = sts.rd_eq ? S_OUT : S_PV_CALC;
      S_PV_CALC:  state_nxt = sts.lo_le_hi ? S_PV_RM : S_L_INIT;
      S_PV_RM:    state_nxt = sts.mid_zero ? S_L_INIT : S_PV_RP;
      S_PV_RP:    state_nxt = S_PV_RH;
      S_PV_RH:    state_nxt = sts.va_lt_rd ? S_L_INIT : S_PV_DEC;
      S_PV_DEC: begin
        if (!sts.va_gt_rd && sts.hi_eq_mid) begin
          state_nxt = S_L_INIT;
        end else begin
          state_nxt = S_PV_CALC;
        end
      end
      S_L_INIT: begin
        if (sts.pivot_is_zero) begin
          state_nxt = S_R_INIT;
        end else begin
          side_nxt  = 1'b0;
          state_nxt = S_BS_CALC;
        end
      end
      S_R_INIT: begin
        side_nxt  = 1'b1;
        state_nxt = S_BS_CALC;
      end
      S_BS_CALC: state_nxt = sts.lo_le_hi ? S_BS_RD : S_BS_END;
      S_BS_RD:   state_nxt = S_BS_CMP;
      S_BS_CMP:  state_nxt = sts.rd_eq ? S_BS_END : S_BS_CALC;
      S_BS_END:  state_nxt = side_r ? S_OUT : S_R_INIT;
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = ADDR_MID;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready    = 1'b1;
        cmd.addr_sel = ADDR_WR;
        if (in_tvalid) begin
          cmd.store  = !in_operation;
          cmd.ld_key = in_operation;
        end
      end
      S_LAST: begin
        cmd.addr_sel = ADDR_LAST;
        cmd.res_none = sts.n_zero;
      end
      S_LAST_CHK: begin
        cmd.res_last = sts.rd_eq;
        cmd.pv_init  = !sts.rd_eq;
      end
      S_PV_CALC: begin
        cmd.calc_mid   = sts.lo_le_hi;
        cmd.pivot_zero = !sts.lo_le_hi;
      end
      S_PV_RM: begin
        cmd.pivot_mid = sts.mid_zero;
        cmd.addr_sel  = ADDR_MID;
      end
      S_PV_RP: begin
        cmd.cap_a    = 1'b1;
        cmd.addr_sel = ADDR_PREV;
      end
      S_PV_RH: begin
        cmd.addr_sel  = ADDR_HI;
        cmd.pivot_mid = sts.va_lt_rd;
      end
      S_PV_DEC: begin
        if (sts.va_gt_rd) begin
          cmd.lo_inc = 1'b1;
        end else if (sts.hi_eq_mid) begin
          cmd.pivot_zero = 1'b1;
        end else begin
          cmd.hi_set_mid = 1'b1;
        end
      end
      S_L_INIT:  cmd.bs_left  = !sts.pivot_is_zero;
      S_R_INIT:  cmd.bs_right = 1'b1;
      S_BS_CALC: cmd.calc_mid = sts.lo_le_hi;
      S_BS_RD:   cmd.addr_sel = ADDR_MID;
      S_BS_CMP: begin
        if (sts.rd_eq) begin
          cmd.bs_found = 1'b1;
        end else if (sts.rd_gt_key) begin
          cmd.hi_dec = 1'b1;
        end else begin
          cmd.lo_inc = 1'b1;
        end
      end
      S_BS_END: begin
        cmd.save_left = !side_r;
        cmd.res_final = side_r;
      end
      S_OUT:   out_tvalid = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// File: test/rotated_sorted_array_search_tb.sv
// Self-checking testbench of the rotated sorted array search block.
`timescale 1ns / 1ps

module rotated_sorted_array_search_tb;
  import rsas_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_SEARCH = 1'b1;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int IDLE_ITEMS = 1450;
  localparam int TOTAL_ITEMS = 1650;

  // Mirrors the element store and predicts the index that each search returns.
  class search_scoreboard;
    logic signed [31:0] elems [DEPTH_DEF];
    int count;
    int errors;
    logic [OUT_W-1:0] index_queue [$];

    function new();
      count = 0;
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function int outstanding();
      return index_queue.size();
    endfunction

    // Gives up with zero when the range narrows to an entry that is no pivot.
    function int find_pivot(int n);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (mid == 0 || elems[mid] < elems[mid-1]) return mid;
        if (elems[mid] > elems[hi]) begin
          lo = mid + 1;
        end else begin
          if (hi == mid) return 0;
          hi = mid;
        end
      end
      return 0;
    endfunction

    function int bsearch_span(int lo, int hi, logic signed [31:0] key);
      int mid;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (elems[mid] == key) return mid;
        if (elems[mid] > key) hi = mid - 1;
        else lo = mid + 1;
      end
      return -1;
    endfunction

    function int locate(logic signed [31:0] key);
      int pivot;
      int left;
      int right;
      left = -1;
      if (count == 0) return -1;
      if (elems[count-1] == key) return count - 1;
      pivot = find_pivot(count);
      if (pivot != 0) left = bsearch_span(0, pivot - 1, key);
      right = bsearch_span(pivot, count - 1, key);
      return (left > right) ? left : right;
    endfunction

    task note_request(logic op, logic signed [31:0] value, logic restart);
      int idx;
      if (op == OP_SEARCH) begin
        idx = locate(value);
        index_queue.push_back(idx[OUT_W-1:0]);
      end else begin
        if (restart) count = 0;
        // A store into a full array is dropped.
        if (count < DEPTH_DEF) begin
          elems[count] = value;
          count++;
        end
      end
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] tdata);
      logic [OUT_W-1:0] want;
      if (index_queue.size() == 0) begin
        report_mismatch($sformatf("result %0h with no search pending", tdata));
      end else begin
        want = index_queue.pop_front();
        if (tdata !== OUT_TDATA_W'(want))
          report_mismatch($sformatf("found_index %0h, predicted %0h", tdata, want));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [VALUE_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  search_scoreboard sb;
  logic signed [31:0] stored_vals [$];
  int sent;
  int quiet_cycles;
  bit idle_on;
  bit hold_long;

  rotated_sorted_array_search #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_request(input logic op, input logic signed [31:0] value,
                              input logic restart);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    in_tuser <= {restart, op};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, value, restart);
    sent++;
  endtask

  // kind: 0 sparse sorted, 1 dense sorted, 2 wide random, 3 small random values.
  task automatic load_set(input int n, input int kind, input logic fresh);
    longint stride;
    longint pos;
    logic [31:0] vals [$];
    int rot;
    logic signed [31:0] v;
    stride = 64'h1_0000_0000 / n;
    pos = longint'($urandom_range(0, 32'hFFFF_FFFF - 3 * n));
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: vals.push_back(32'(i * stride + $urandom_range(0, 32'(stride - 1))));
        1: begin
          if (i > 0) pos += $urandom_range(1, 3);
          vals.push_back(pos[31:0]);
        end
        2: vals.push_back($urandom);
        default: vals.push_back($urandom_range(0, 7) ^ 32'h8000_0000);
      endcase
    end
    rot = $urandom_range(0, n - 1);
    if (fresh) stored_vals.delete();
    for (int i = 0; i < n; i++) begin
      // Offsets are unsigned; flipping the sign bit keeps their order as signed.
      v = vals[(i + rot) % n] ^ 32'h8000_0000;
      send_request(OP_STORE, v, (i == 0) && fresh);
      stored_vals.push_back(v);
    end
  endtask

  task automatic search_some(input int k);
    logic signed [31:0] key;
    repeat (k) begin
      case ($urandom_range(0, 5))
        0, 1: key = stored_vals[$urandom_range(0, stored_vals.size() - 1)];
        2: key = stored_vals[$urandom_range(0, stored_vals.size() - 1)] + 1;
        3: key = $urandom;
        4: key = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        default: key = stored_vals[stored_vals.size() - 1];
      endcase
      send_request(OP_SEARCH, key, $urandom_range(0, 1));
    end
  endtask

  task automatic run_sets(input int upto);
    int n;
    int pick;
    int kind;
    while (sent < upto) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
      pick = $urandom_range(0, 9);
      kind = (pick < 5) ? 0 : (pick < 8) ? 1 : (pick == 8) ? 2 : 3;
      // An occasional set lacks the restart and runs on from the previous one.
      load_set(n, kind, $urandom_range(0, 9) != 0);
      search_some($urandom_range(2, 8));
    end
  endtask

  // Receiver: random stalls, and one long hold-off so the block backs up.
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    sent = 0;
    idle_on = 1'b1;
    hold_long = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Searches on an empty store, with the restart bit that a search ignores.
    send_request(OP_SEARCH, 32'sd0, 1'b1);
    send_request(OP_SEARCH, VAL_MIN, 1'b0);
    // Single element at the bottom of the range.
    send_request(OP_STORE, VAL_MIN, 1'b1);
    send_request(OP_SEARCH, VAL_MIN, 1'b0);
    send_request(OP_SEARCH, VAL_MAX, 1'b0);
    // Rotated array that holds both extremes around the pivot.
    send_request(OP_STORE, 32'sd5, 1'b1);
    send_request(OP_STORE, 32'sd7, 1'b0);
    send_request(OP_STORE, VAL_MAX, 1'b0);
    send_request(OP_STORE, VAL_MIN, 1'b0);
    send_request(OP_STORE, -32'sd3, 1'b0);
    send_request(OP_SEARCH, -32'sd3, 1'b0);
    send_request(OP_SEARCH, VAL_MAX, 1'b1);
    send_request(OP_SEARCH, VAL_MIN, 1'b0);
    send_request(OP_SEARCH, 32'sd6, 1'b0);
    send_request(OP_SEARCH, 32'sd5, 1'b0);
    // Unsorted contents with a repeated value.
    send_request(OP_STORE, 32'sd9, 1'b1);
    send_request(OP_STORE, 32'sd2, 1'b0);
    send_request(OP_STORE, 32'sd9, 1'b0);
    send_request(OP_STORE, 32'sd4, 1'b0);
    send_request(OP_SEARCH, 32'sd4, 1'b0);
    send_request(OP_SEARCH, 32'sd9, 1'b0);
    send_request(OP_SEARCH, 32'sd2, 1'b0);

    // Fill the store completely; the extra stores must be dropped.
    load_set(DEPTH, 0, 1'b1);
    repeat (3) send_request(OP_STORE, $urandom, 1'b0);
    hold_long = 1'b1;
    search_some(12);

    run_sets(IDLE_ITEMS);
    idle_on = 1'b0;
    run_sets(TOTAL_ITEMS);

    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
